/* src/assert_macros.svh */
// assertion macros for the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SALRU_ASSERT(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define SALRU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SALRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SALRU_ASSERT(label, clk, rst, expr, msg)

`define SALRU_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define SALRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* src/salru_pkg.sv */
// shared types and constants for the set associative lru lookup
package salru_pkg;

   localparam int SALRU_SETS     = 64;
   localparam int SALRU_WAYS     = 8;
   localparam int SALRU_AGE_BITS = 16;

   localparam int ADDR_W       = 32;
   localparam int TAG_W        = 32;
   localparam int WAY_W        = 3;
   localparam int SET_OUT_W    = 6;
   localparam int CNT_W        = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 4;
   localparam int OFFSET_CFG_W = 4;
   localparam int INDEX_CFG_W  = 3;
   localparam int WAYS_CFG_W   = 4;
   localparam int SHAMT_W      = 5;
   localparam int SET_RAW_N    = 64;
   localparam int MAX_LANES    = 8;

   localparam logic [OFFSET_CFG_W-1:0] OFFSET_MAX   = 4'd12;
   localparam logic [INDEX_CFG_W-1:0]  INDEX_MAX    = 3'd6;
   localparam logic [WAYS_CFG_W-1:0]   WAYS_MAX     = 4'd8;
   localparam logic [OFFSET_CFG_W-1:0] OFFSET_RESET = 4'd6;
   localparam logic [INDEX_CFG_W-1:0]  INDEX_RESET  = 3'd6;
   localparam logic [WAYS_CFG_W-1:0]   WAYS_RESET   = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS_IN_USE = 2'd2
   } salru_csr_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } salru_state_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic             evicted;
      logic [TAG_W-1:0] evicted_tag;
   } salru_result_type;

endpackage

/* src/salru_tag_ram.sv */
// one row per set: valid, tag and age of every way, one write and one registered read port
module salru_tag_ram #(
   parameter int ROWS     = 64,
   parameter int ROW_BITS = 392,
   parameter int ROW_W    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ROW_W-1:0]    wr_addr,
   input  logic [ROW_BITS-1:0] wr_data,
   input  logic                rd_en,
   input  logic [ROW_W-1:0]    rd_addr,
   output logic [ROW_BITS-1:0] rd_data
);

   logic [ROW_BITS-1:0] mem_ff [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/salru_decide.sv */
// hit search, victim choice and age update for one set row
module salru_decide #(
   parameter int LANE     = 8,
   parameter int AGE_BITS = 16
) (
   input  logic [LANE*(1+salru_pkg::TAG_W+AGE_BITS)-1:0] row_in,
   input  logic [salru_pkg::TAG_W-1:0]                   tag_in,
   input  logic [salru_pkg::WAYS_CFG_W-1:0]              ways,
   output logic [LANE*(1+salru_pkg::TAG_W+AGE_BITS)-1:0] row_out,
   output salru_pkg::salru_result_type                   result
);

   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   logic [LANE-1:0]                          valid_q;
   logic [LANE-1:0][salru_pkg::TAG_W-1:0]    tag_q;
   logic [LANE-1:0][AGE_BITS-1:0]            age_q;
   logic [LANE-1:0]                          valid_d;
   logic [LANE-1:0][salru_pkg::TAG_W-1:0]    tag_d;
   logic [LANE-1:0][AGE_BITS-1:0]            age_d;

   assign {valid_q, tag_q, age_q} = row_in;
   assign row_out = {valid_d, tag_d, age_d};

   always_comb begin
      logic                          hit;
      logic [salru_pkg::WAY_W-1:0]   hit_way;
      logic                          found_empty;
      logic [salru_pkg::WAY_W-1:0]   free_way;
      logic [salru_pkg::WAY_W-1:0]   best;
      logic [AGE_BITS-1:0]           best_age;
      logic [salru_pkg::WAY_W-1:0]   sel;
      logic                          evicted;
      logic [salru_pkg::TAG_W-1:0]   ev_tag;
      logic                          in_use;

      hit         = 1'b0;
      hit_way     = '0;
      found_empty = 1'b0;
      free_way    = '0;
      best        = '0;
      best_age    = age_q[0];
      ev_tag      = '0;
      valid_d     = valid_q;
      tag_d       = tag_q;
      age_d       = age_q;

      for (int i = 0; i < LANE; i++) begin
         in_use = salru_pkg::WAYS_CFG_W'(i) < ways;
         if (!hit && in_use && valid_q[i] && tag_q[i] == tag_in) begin
            hit     = 1'b1;
            hit_way = salru_pkg::WAY_W'(i);
         end
         if (!found_empty && in_use && !valid_q[i]) begin
            found_empty = 1'b1;
            free_way    = salru_pkg::WAY_W'(i);
         end
         if (i > 0 && in_use && age_q[i] > best_age) begin
            best_age = age_q[i];
            best     = salru_pkg::WAY_W'(i);
         end
      end

      evicted = !hit && !found_empty;
      if (hit) begin
         sel = hit_way;
      end else if (found_empty) begin
         sel = free_way;
      end else begin
         sel = best;
      end

      for (int i = 0; i < LANE; i++) begin
         in_use = salru_pkg::WAYS_CFG_W'(i) < ways;
         if (evicted && salru_pkg::WAY_W'(i) == best) begin
            ev_tag = tag_q[i];
         end
         if (!hit && salru_pkg::WAY_W'(i) == sel) begin
            valid_d[i] = 1'b1;
            tag_d[i]   = tag_in;
         end
         if (in_use && valid_d[i] && age_q[i] != AGE_MAX) begin
            age_d[i] = age_q[i] + AGE_BITS'(1);
         end
         if (salru_pkg::WAY_W'(i) == sel) begin
            age_d[i] = '0;
         end
      end

      result.hit         = hit;
      result.way         = sel;
      result.evicted     = evicted;
      result.evicted_tag = ev_tag;
   end

endmodule

/* src/set_assoc_cache_lru_lookup_core.sv */
// set associative cache tag lookup with age based lru replacement, top level
// a request is accepted in ST_IDLE; ST_LOOKUP compares and writes back the row and
// registers the result, raising rsp_valid; a held result keeps ST_LOOKUP waiting, and no
// new request is taken until the row read, compare and write-back of the last one are done
// reset: synchronous; then ST_CLEAR clears all min(SETS,64) tag ram rows with req_stall high
// counters clear on reset; the csr port is always ready
`include "assert_macros.svh"

module set_assoc_cache_lru_lookup_core #(
   parameter int SETS     = salru_pkg::SALRU_SETS,
   parameter int WAYS     = salru_pkg::SALRU_WAYS,
   parameter int AGE_BITS = salru_pkg::SALRU_AGE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [salru_pkg::ADDR_W-1:0]        req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [salru_pkg::WAY_W-1:0]         rsp_way,
   output logic [salru_pkg::SET_OUT_W-1:0]     rsp_set_index,
   output logic                                rsp_evicted,
   output logic [salru_pkg::TAG_W-1:0]         rsp_evicted_tag,
   output logic [salru_pkg::CNT_W-1:0]         rsp_hit_count,
   output logic [salru_pkg::CNT_W-1:0]         rsp_miss_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [salru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [salru_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int LANE     = WAYS < salru_pkg::MAX_LANES ? WAYS : salru_pkg::MAX_LANES;
   localparam int ROWS     = SETS < salru_pkg::SET_RAW_N ? SETS : salru_pkg::SET_RAW_N;
   localparam int ROW_W    = ROWS > 1 ? $clog2(ROWS) : 1;
   localparam int ROW_BITS = LANE * (1 + salru_pkg::TAG_W + AGE_BITS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [salru_pkg::WAYS_CFG_W-1:0] LANE_CFG = salru_pkg::WAYS_CFG_W'(LANE);

   // configuration
   logic [salru_pkg::OFFSET_CFG_W-1:0] offset_bits_ff;
   logic [salru_pkg::INDEX_CFG_W-1:0]  index_bits_ff;
   logic [salru_pkg::WAYS_CFG_W-1:0]   ways_in_use_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= salru_pkg::OFFSET_RESET;
         index_bits_ff  <= salru_pkg::INDEX_RESET;
         ways_in_use_ff <= salru_pkg::WAYS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            salru_pkg::CSR_OFFSET_BITS: offset_bits_ff <= csr_data;
            salru_pkg::CSR_INDEX_BITS:  index_bits_ff  <= csr_data[salru_pkg::INDEX_CFG_W-1:0];
            salru_pkg::CSR_WAYS_IN_USE: ways_in_use_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // address split
   logic [salru_pkg::OFFSET_CFG_W-1:0] ob;
   logic [salru_pkg::INDEX_CFG_W-1:0]  ib;
   logic [salru_pkg::WAYS_CFG_W-1:0]   nways;
   logic [6:0]                         idx_mask;
   logic [salru_pkg::ADDR_W-1:0]       addr_shift;
   logic [salru_pkg::SET_OUT_W-1:0]    set_raw;
   logic [salru_pkg::SHAMT_W-1:0]      tag_shamt;
   logic [salru_pkg::TAG_W-1:0]        tag_comb;
   logic [ROW_W-1:0]                   row_comb;
   logic [ROW_W-1:0]                   set_mod_tbl [salru_pkg::SET_RAW_N];

   for (genvar v = 0; v < salru_pkg::SET_RAW_N; v++) begin : g_set_mod
      assign set_mod_tbl[v] = ROW_W'(v % SETS);
   end

   always_comb begin
      ob = offset_bits_ff > salru_pkg::OFFSET_MAX ? salru_pkg::OFFSET_MAX : offset_bits_ff;
      ib = index_bits_ff > salru_pkg::INDEX_MAX ? salru_pkg::INDEX_MAX : index_bits_ff;
      if (ways_in_use_ff == '0) begin
         nways = salru_pkg::WAYS_CFG_W'(1);
      end else if (ways_in_use_ff > salru_pkg::WAYS_MAX) begin
         nways = salru_pkg::WAYS_MAX;
      end else begin
         nways = ways_in_use_ff;
      end
      if (nways > LANE_CFG) begin
         nways = LANE_CFG;
      end
      idx_mask   = (7'd1 << ib) - 7'd1;
      addr_shift = req_address >> ob;
      set_raw    = addr_shift[salru_pkg::SET_OUT_W-1:0] & idx_mask[salru_pkg::SET_OUT_W-1:0];
      tag_shamt  = salru_pkg::SHAMT_W'(ob) + salru_pkg::SHAMT_W'(ib);
      tag_comb   = req_address >> tag_shamt;
      row_comb   = set_mod_tbl[set_raw];
   end

   // control
   salru_pkg::salru_state_type state_ff, state_in;
   logic [ROW_W-1:0]             clr_cnt_ff, clr_cnt_in;
   logic [salru_pkg::TAG_W-1:0]  tag_ff;
   logic [ROW_W-1:0]             row_ff;
   logic                         accept;
   logic                         done;
   logic                         mem_wr_en;
   logic [ROW_W-1:0]             mem_wr_addr;
   logic [ROW_BITS-1:0]          mem_wr_data;
   logic [ROW_BITS-1:0]          mem_rd_data;
   logic [ROW_BITS-1:0]          row_new;
   salru_pkg::salru_result_type  result;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_hit_ff;
   logic [salru_pkg::WAY_W-1:0]         rsp_way_ff;
   logic [salru_pkg::SET_OUT_W-1:0]     rsp_set_ff;
   logic                                rsp_evicted_ff;
   logic [salru_pkg::TAG_W-1:0]         rsp_evicted_tag_ff;
   logic [salru_pkg::CNT_W-1:0]         hits_ff, hits_in;
   logic [salru_pkg::CNT_W-1:0]         misses_ff, misses_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salru_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ROW) begin
               state_in = salru_pkg::ST_IDLE;
            end
         end
         salru_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = salru_pkg::ST_LOOKUP;
            end
         end
         salru_pkg::ST_LOOKUP: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               state_in = salru_pkg::ST_IDLE;
            end
         end
         default: state_in = salru_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      done        = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = row_ff;
      mem_wr_data = row_new;
      clr_cnt_in  = clr_cnt_ff;
      case (state_ff)
         salru_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + ROW_W'(1);
         end
         salru_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         salru_pkg::ST_LOOKUP: begin
            done      = !(rsp_valid_ff && rsp_stall);
            mem_wr_en = done;
         end
         default: ;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= salru_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff <= tag_comb;
         row_ff <= row_comb;
      end
   end

   salru_tag_ram #(
      .ROWS     (ROWS),
      .ROW_BITS (ROW_BITS),
      .ROW_W    (ROW_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (row_comb),
      .rd_data (mem_rd_data)
   );

   salru_decide #(
      .LANE     (LANE),
      .AGE_BITS (AGE_BITS)
   ) u_decide (
      .row_in  (mem_rd_data),
      .tag_in  (tag_ff),
      .ways    (nways),
      .row_out (row_new),
      .result  (result)
   );

   // counters and result register
   assign hits_in      = hits_ff + salru_pkg::CNT_W'(result.hit);
   assign misses_in    = misses_ff + salru_pkg::CNT_W'(!result.hit);
   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            hits_ff   <= hits_in;
            misses_ff <= misses_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_hit_ff         <= result.hit;
         rsp_way_ff         <= result.way;
         rsp_set_ff         <= salru_pkg::SET_OUT_W'(row_ff);
         rsp_evicted_ff     <= result.evicted;
         rsp_evicted_tag_ff <= result.evicted_tag;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_way         = rsp_way_ff;
   assign rsp_set_index   = rsp_set_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_tag = rsp_evicted_tag_ff;
   assign rsp_hit_count   = hits_ff;
   assign rsp_miss_count  = misses_ff;

   `SALRU_ASSERT_NEXT(a_accept_to_lookup, clock, reset, accept, state_ff == salru_pkg::ST_LOOKUP, "accepted request did not start a lookup")
   `SALRU_ASSERT_NEXT(a_one_count_step, clock, reset, done, (hits_ff + misses_ff) == salru_pkg::CNT_W'($past(hits_ff) + $past(misses_ff) + salru_pkg::CNT_W'(1)), "totals did not advance by one")
   `SALRU_ASSERT_IMPL(a_hit_no_evict, clock, reset, rsp_valid_ff, !(rsp_hit_ff && rsp_evicted_ff), "hit reported with an eviction")
   `SALRU_ASSERT_IMPL(a_evict_tag_zero, clock, reset, rsp_valid_ff && !rsp_evicted_ff, rsp_evicted_tag_ff == '0, "evicted tag set without eviction")
   `SALRU_ASSERT_IMPL(a_no_write_idle, clock, reset, state_ff == salru_pkg::ST_IDLE, !mem_wr_en, "tag ram written while idle")

endmodule

/* verif/lru_lookup_checker.sv */
// checker for the set associative lru lookup: predicts each lookup and compares the results
module lru_lookup_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [salru_pkg::ADDR_W-1:0]      req_address,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_hit,
   input  logic [salru_pkg::WAY_W-1:0]       rsp_way,
   input  logic [salru_pkg::SET_OUT_W-1:0]   rsp_set_index,
   input  logic                              rsp_evicted,
   input  logic [salru_pkg::TAG_W-1:0]       rsp_evicted_tag,
   input  logic [salru_pkg::CNT_W-1:0]       rsp_hit_count,
   input  logic [salru_pkg::CNT_W-1:0]       rsp_miss_count,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [salru_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [salru_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                mismatches,
   output int unsigned                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_COUNT = salru_pkg::SALRU_SETS * salru_pkg::SALRU_WAYS;
   localparam int LINE_W     = $clog2(LINE_COUNT);

   typedef struct packed {
      logic                            hit;
      logic [salru_pkg::WAY_W-1:0]     way;
      logic [salru_pkg::SET_OUT_W-1:0] set_index;
      logic                            evicted;
      logic [salru_pkg::TAG_W-1:0]     evicted_tag;
      logic [salru_pkg::CNT_W-1:0]     hit_count;
      logic [salru_pkg::CNT_W-1:0]     miss_count;
   } lookup_outcome_type;

   logic [salru_pkg::OFFSET_CFG_W-1:0]   geo_offset;
   logic [salru_pkg::INDEX_CFG_W-1:0]    geo_index;
   logic [salru_pkg::WAYS_CFG_W-1:0]     geo_ways;
   logic                                 way_valid [LINE_COUNT];
   logic [salru_pkg::TAG_W-1:0]          way_tag [LINE_COUNT];
   logic [salru_pkg::SALRU_AGE_BITS-1:0] way_age [LINE_COUNT];
   logic [salru_pkg::CNT_W-1:0]          hit_tally;
   logic [salru_pkg::CNT_W-1:0]          miss_tally;
   lookup_outcome_type                   outcomes_due [$];

   function automatic lookup_outcome_type predict_lookup(
         input logic [salru_pkg::ADDR_W-1:0] addr);
      lookup_outcome_type r;
      int unsigned ob, ib, nw, set_no, base, sel, w;
      logic [LINE_W-1:0] li;
      logic [salru_pkg::TAG_W-1:0] tag;
      logic [salru_pkg::SALRU_AGE_BITS-1:0] oldest;
      bit found, empty;
      ob = 32'((geo_offset > salru_pkg::OFFSET_MAX) ? salru_pkg::OFFSET_MAX : geo_offset);
      ib = 32'((geo_index > salru_pkg::INDEX_MAX) ? salru_pkg::INDEX_MAX : geo_index);
      nw = (geo_ways == '0) ? 1 : 32'(geo_ways);
      if (nw > 32'(salru_pkg::WAYS_MAX)) nw = 32'(salru_pkg::WAYS_MAX);
      if (nw > salru_pkg::SALRU_WAYS) nw = salru_pkg::SALRU_WAYS;
      set_no = ((addr >> ob) & ((32'd1 << ib) - 32'd1)) % salru_pkg::SALRU_SETS;
      tag = addr >> (ob + ib);
      base = set_no * salru_pkg::SALRU_WAYS;
      r = '0;
      found = 1'b0;
      empty = 1'b0;
      sel = 0;
      for (w = 0; w < nw; w++) begin
         li = LINE_W'(base + w);
         if (!found && way_valid[li] && way_tag[li] == tag) begin
            found = 1'b1;
            sel = w;
         end
      end
      if (found) begin
         hit_tally++;
      end else begin
         miss_tally++;
         oldest = '0;
         for (w = 0; w < nw; w++) begin
            li = LINE_W'(base + w);
            if (!empty && !way_valid[li]) begin
               empty = 1'b1;
               sel = w;
            end else if (!empty && (w == 0 || way_age[li] > oldest)) begin
               oldest = way_age[li];
               sel = w;
            end
         end
         li = LINE_W'(base + sel);
         if (!empty) begin
            r.evicted = 1'b1;
            r.evicted_tag = way_tag[li];
         end
         way_valid[li] = 1'b1;
         way_tag[li] = tag;
      end
      // saturating age update over the ways in use
      for (w = 0; w < nw; w++) begin
         li = LINE_W'(base + w);
         if (way_valid[li] && way_age[li] != '1) way_age[li]++;
      end
      way_age[LINE_W'(base + sel)] = '0;
      r.hit = found;
      r.way = salru_pkg::WAY_W'(sel);
      r.set_index = salru_pkg::SET_OUT_W'(set_no);
      r.hit_count = hit_tally;
      r.miss_count = miss_tally;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: lookup mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", what, got, want));
      end
   endtask

   always @(posedge clock) begin : watch
      lookup_outcome_type want;
      if (reset) begin
         geo_offset = salru_pkg::OFFSET_RESET;
         geo_index = salru_pkg::INDEX_RESET;
         geo_ways = salru_pkg::WAYS_RESET;
         for (int i = 0; i < LINE_COUNT; i++) begin
            way_valid[LINE_W'(i)] = 1'b0;
            way_tag[LINE_W'(i)] = '0;
            way_age[LINE_W'(i)] = '0;
         end
         hit_tally = '0;
         miss_tally = '0;
         outcomes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               salru_pkg::CSR_OFFSET_BITS: geo_offset = csr_data;
               salru_pkg::CSR_INDEX_BITS: geo_index = csr_data[salru_pkg::INDEX_CFG_W-1:0];
               salru_pkg::CSR_WAYS_IN_USE: geo_ways = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = outcomes_due.pop_front();
               compare_field("hit", 32'(rsp_hit), 32'(want.hit));
               compare_field("way", 32'(rsp_way), 32'(want.way));
               compare_field("set_index", 32'(rsp_set_index), 32'(want.set_index));
               compare_field("evicted", 32'(rsp_evicted), 32'(want.evicted));
               compare_field("evicted_tag", rsp_evicted_tag, want.evicted_tag);
               compare_field("hit_count", rsp_hit_count, want.hit_count);
               compare_field("miss_count", rsp_miss_count, want.miss_count);
            end
         end
         if (req_valid && !req_stall) outcomes_due.push_back(predict_lookup(req_address));
      end
      outstanding <= outcomes_due.size();
   end

endmodule

/* verif/tb_top.sv */
// testbench top for the set associative lru lookup: stimulus, stalls and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [salru_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DUP_SET   = 21;
   localparam int BURST_SET = 37;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [salru_pkg::ADDR_W-1:0]     req_address;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic                             rsp_hit;
   logic [salru_pkg::WAY_W-1:0]      rsp_way;
   logic [salru_pkg::SET_OUT_W-1:0]  rsp_set_index;
   logic                             rsp_evicted;
   logic [salru_pkg::TAG_W-1:0]      rsp_evicted_tag;
   logic [salru_pkg::CNT_W-1:0]      rsp_hit_count;
   logic [salru_pkg::CNT_W-1:0]      rsp_miss_count;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [salru_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [salru_pkg::CSR_DATA_W-1:0] csr_data;
   int                               mismatches;
   int unsigned                      outstanding;

   bit                               calm;
   int                               lookups_sent;
   int                               geometries;
   int                               cur_ob;
   int                               cur_ib;
   logic [salru_pkg::ADDR_W-1:0]     tag_pool [10];
   logic [salru_pkg::SET_OUT_W-1:0]  set_pool [3];

   set_assoc_cache_lru_lookup_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_way         (rsp_way),
      .rsp_set_index   (rsp_set_index),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_tag (rsp_evicted_tag),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_miss_count  (rsp_miss_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   lru_lookup_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_way         (rsp_way),
      .rsp_set_index   (rsp_set_index),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_tag (rsp_evicted_tag),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_miss_count  (rsp_miss_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || calm) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 28);
   end

   task automatic send_request(input logic [salru_pkg::ADDR_W-1:0] addr);
      if (!calm) begin
         while ($urandom_range(0, 99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lookups_sent++;
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [salru_pkg::CSR_IDX_W-1:0] idx,
                            input logic [salru_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [salru_pkg::CSR_DATA_W-1:0] ob,
                               input logic [salru_pkg::CSR_DATA_W-1:0] ib,
                               input logic [salru_pkg::CSR_DATA_W-1:0] ways);
      write_csr(salru_pkg::CSR_OFFSET_BITS, ob);
      write_csr(salru_pkg::CSR_INDEX_BITS, ib);
      write_csr(salru_pkg::CSR_WAYS_IN_USE, ways);
      cur_ob = int'((ob > salru_pkg::OFFSET_MAX) ? salru_pkg::OFFSET_MAX : ob);
      cur_ib = int'((ib[salru_pkg::INDEX_CFG_W-1:0] > salru_pkg::INDEX_MAX)
                    ? salru_pkg::INDEX_MAX : ib[salru_pkg::INDEX_CFG_W-1:0]);
      geometries++;
      // small working set so that lines get reused and evicted
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < 10; i++) begin
         tag_pool[4'(i)] = (i < 7) ? $urandom_range(0, 15) : $urandom;
      end
      for (int i = 0; i < 3; i++) begin
         set_pool[2'(i)] = salru_pkg::SET_OUT_W'($urandom_range(0, 63));
      end
   endtask

   initial begin : stimulus
      logic [salru_pkg::ADDR_W-1:0] addr;
      clock = 1'b0;
      reset = 1'b1;
      calm = 1'b0;
      rsp_stall = 1'b0;
      req_valid = 1'b0;
      req_address = '0;
      csr_valid = 1'b0;
      csr_index = salru_pkg::CSR_OFFSET_BITS;
      csr_data = '0;
      lookups_sent = 0;
      geometries = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: extremes, repeat hits and a full set
      send_request(32'h0000_0000);
      send_request(32'hFFFF_FFFF);
      send_request(32'h0000_0000);
      send_request(32'hFFFF_FFFF);
      send_request(32'h0000_003F);
      send_request(32'h8000_0000);
      for (int t = 1; t <= 9; t++) send_request(t << 12);
      wait_quiet();

      // out of range offset and index, zero ways in use
      set_geometry(4'd15, 4'd15, 4'd0);
      send_request(32'd5 << 18);
      send_request((32'd6 << 18) | 32'hFFF);
      send_request(32'd5 << 18);
      wait_quiet();

      // same tag in two ways, lowest one must hit
      set_geometry(4'd0, 4'd6, 4'd2);
      send_request((32'd1 << 6) | DUP_SET);
      send_request((32'd2 << 6) | DUP_SET);
      wait_quiet();
      write_csr(salru_pkg::CSR_WAYS_IN_USE, 4'd1);
      send_request((32'd2 << 6) | DUP_SET);
      wait_quiet();
      write_csr(salru_pkg::CSR_WAYS_IN_USE, 4'd2);
      send_request((32'd2 << 6) | DUP_SET);
      wait_quiet();
      write_csr(CSR_UNUSED, salru_pkg::CSR_DATA_W'($urandom_range(0, 15)));
      write_csr(salru_pkg::CSR_WAYS_IN_USE, 4'd15);
      send_request((32'd2 << 6) | DUP_SET);
      wait_quiet();

      // same-set burst with no idling on either side, oldest line gets evicted
      set_geometry(4'd0, 4'd6, 4'd3);
      calm = 1'b1;
      send_request((32'd1 << 6) | BURST_SET);
      repeat (30) send_request((32'd2 << 6) | BURST_SET);
      send_request((32'd3 << 6) | BURST_SET);
      repeat (10) send_request((32'd2 << 6) | BURST_SET);
      send_request((32'd4 << 6) | BURST_SET);
      calm = 1'b0;
      wait_quiet();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_geometry(4'd0, 4'd0, 4'd1);
            1: set_geometry(4'd12, 4'd6, 4'd8);
            2: set_geometry(4'd15, 4'd15, 4'd15);
            3: set_geometry(4'd3, 4'd2, 4'd4);
            default: set_geometry(salru_pkg::CSR_DATA_W'($urandom_range(0, 15)),
                                  salru_pkg::CSR_DATA_W'($urandom_range(0, 15)),
                                  salru_pkg::CSR_DATA_W'($urandom_range(0, 15)));
         endcase
         for (int n = 0; n < 148; n++) begin
            if ($urandom_range(0, 59) == 0) wait_quiet();
            if ($urandom_range(0, 99) < 15) begin
               addr = $urandom;
            end else begin
               addr = (tag_pool[4'($urandom_range(0, 9))] << (cur_ob + cur_ib))
                    | ((32'(set_pool[2'($urandom_range(0, 2))]) & ((32'd1 << cur_ib) - 32'd1))
                       << cur_ob)
                    | ($urandom & ((32'd1 << cur_ob) - 32'd1));
            end
            send_request(addr);
         end
         wait_quiet();
      end

      $display("covered %0d lookups over %0d cache geometries, incl. duplicate tags",
               lookups_sent, geometries);
      $display("and a same-set burst with no idling that forces an lru eviction");
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(10_000_000);
      $display("tb_top failed");
      $finish;
   end

endmodule
